// ===== hdl/nmmf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmmf_pkg
// Shared constants of the neighbourhood mean / max / min filter.
// ----------------------------------------------------------------------------
package nmmf_pkg;

  localparam int unsigned MaxWidthDef = 1024;
  localparam int unsigned HalfMaxDef  = 3;
  localparam int unsigned MaxHeight   = 4096;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 13;
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned HalfW   = 2;
  localparam int unsigned ModeW   = 2;

  localparam logic [CfgIdxW-1:0] RegWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegHalf   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMode   = 2'd3;

  localparam logic [ModeW-1:0] ModeMean = 2'd0;
  localparam logic [ModeW-1:0] ModeMax  = 2'd1;
  localparam logic [ModeW-1:0] ModeMin  = 2'd2;

  localparam logic ActPixel = 1'b0;
  localparam logic ActDrain = 1'b1;

endpackage
`default_nettype wire

// ===== hdl/nmmf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nmmf_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module nmmf_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/neighborhood_mean_max_min_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neighborhood_mean_max_min_filter_top
// Raster neighbourhood mean / maximum / minimum filter over a banked line store.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and are written into a line store of
// 2*HalfMax+2 row banks held in one single-port RAM. Each accepted pixel
// word is stored first; if the window of the next output pixel is then
// complete, the window is read one cell a cycle, and a mean with a nonzero
// count runs a restoring divider. Because of the single RAM port and the
// divider, a new word is not taken while the last one is still in work.
// Out-of-image cells are left out of the result. The result waits in an
// output register; the next word is taken as soon as the previous one has
// moved into that register.
// ----------------------------------------------------------------------------
module neighborhood_mean_max_min_filter_top #(
  parameter int unsigned MaxWidth = nmmf_pkg::MaxWidthDef,
  parameter int unsigned HalfMax  = nmmf_pkg::HalfMaxDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] value
  output logic             m_axis_tlast,   // frame_last
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [nmmf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [nmmf_pkg::CfgDatW-1:0] cfg_data_i
);

  localparam int unsigned Banks = 2 * HalfMax + 2;
  localparam int unsigned BankW = $clog2(Banks);
  localparam int unsigned ColW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned Depth = Banks * MaxWidth;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RowW  = $clog2(nmmf_pkg::MaxHeight);
  localparam int unsigned OffW  = $clog2(2 * HalfMax + 1) + 2;
  localparam int unsigned SumW  = 23;
  localparam int unsigned CntW  = 8;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWrite = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StLast  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;

  logic [nmmf_pkg::WidthW-1:0]  width_q;
  logic [nmmf_pkg::HeightW-1:0] height_q;
  logic [nmmf_pkg::HalfW-1:0]   half_q;
  logic [nmmf_pkg::ModeW-1:0]   mode_q;

  logic [ColW-1:0]  in_col_q, out_col_q;
  logic [RowW-1:0]  in_row_q, out_row_q;
  logic [BankW-1:0] in_bank_q, out_bank_q;
  logic             in_frame_q, out_frame_q;

  logic                act_q;
  logic [15:0]         smp_q;

  logic signed [OffW-1:0] d_q, e_q;
  logic                   rd_pend_q;
  logic signed [SumW-1:0] sum_q;
  logic signed [15:0]     best_q;
  logic [CntW-1:0]        cnt_q;
  logic [SumW-1:0]        rem_q, quo_q;
  logic [4:0]             dstep_q;
  logic                   neg_q;

  logic [15:0] res_q;
  logic        res_last_q, res_vld_q;

  // effective configuration
  logic [ColW:0]  wid_e;
  logic [RowW:0]  hgt_e;
  logic [OffW-1:0] k_e;
  always_comb begin
    if (width_q == '0) wid_e = (ColW+1)'(1);
    else if (32'(width_q) > MaxWidth) wid_e = (ColW+1)'(MaxWidth);
    else wid_e = (ColW+1)'(width_q);
    if (height_q == '0) hgt_e = (RowW+1)'(1);
    else if (32'(height_q) > nmmf_pkg::MaxHeight) hgt_e = (RowW+1)'(nmmf_pkg::MaxHeight);
    else hgt_e = (RowW+1)'(height_q);
    if (32'(half_q) > HalfMax) k_e = OffW'(HalfMax);
    else k_e = OffW'(half_q);
  end

  // readiness
  logic        ready_w;
  logic [RowW+OffW:0] lr, lc;
  always_comb begin
    lr = (RowW+OffW+1)'(out_row_q) + (RowW+OffW+1)'(k_e);
    if (lr > (RowW+OffW+1)'(hgt_e) - 1'b1) lr = (RowW+OffW+1)'(hgt_e) - 1'b1;
    lc = (RowW+OffW+1)'(out_col_q) + (RowW+OffW+1)'(k_e);
    if (lc > (RowW+OffW+1)'(wid_e) - 1'b1) lc = (RowW+OffW+1)'(wid_e) - 1'b1;
    ready_w = (in_frame_q != out_frame_q) ||
              ((RowW+OffW+1)'(in_row_q) > lr) ||
              (((RowW+OffW+1)'(in_row_q) == lr) && ((RowW+OffW+1)'(in_col_q) > lc));
  end

  // current window cell
  logic signed [RowW+OffW+1:0] r_s, c_s;
  logic                        cell_in;
  logic [BankW+OffW:0]         bsum;
  logic [BankW-1:0]            rbank;
  always_comb begin
    r_s = $signed({2'b00, out_row_q}) + (RowW+OffW+2)'(d_q);
    c_s = $signed({2'b00, out_col_q}) + (RowW+OffW+2)'(e_q);
    cell_in = (r_s >= 0) && (r_s < $signed({1'b0, hgt_e})) &&
              (c_s >= 0) && (c_s < $signed({1'b0, wid_e}));
    bsum = (BankW+OffW+1)'(out_bank_q) + (BankW+OffW+1)'(Banks) + (BankW+OffW+1)'(d_q);
    if (bsum >= (BankW+OffW+1)'(2 * Banks)) begin
      bsum = bsum - (BankW+OffW+1)'(2 * Banks);
    end else if (bsum >= (BankW+OffW+1)'(Banks)) begin
      bsum = bsum - (BankW+OffW+1)'(Banks);
    end
    rbank = BankW'(bsum);
  end

  logic last_cell;
  assign last_cell = (d_q == $signed(k_e)) && (e_q == $signed(k_e));

  // RAM port
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [15:0]      ram_rdata;
  always_comb begin
    ram_we = (state_q == StWrite) && (act_q == nmmf_pkg::ActPixel);
    if (state_q == StWrite) begin
      ram_addr = AddrW'(in_bank_q * MaxWidth + in_col_q);
    end else begin
      ram_addr = AddrW'(rbank * MaxWidth + c_s[ColW-1:0]);
    end
  end

  nmmf_ram #(.Width(16), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(smp_q),
    .rdata_o(ram_rdata)
  );

  logic signed [15:0] rv;
  assign rv = $signed(ram_rdata);

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = res_q;

  logic out_wrap_col, out_wrap_row;
  assign out_wrap_col = (ColW+1)'(out_col_q) + 1'b1 >= wid_e;
  assign out_wrap_row = (RowW+1)'(out_row_q) + 1'b1 >= hgt_e;
  assign m_axis_tlast = res_last_q;

  // restoring divide step
  logic [SumW:0] trial;
  assign trial = {rem_q[SumW-2:0], quo_q[SumW-1]} - (SumW+1)'(cnt_q);

  // window totals with the last pending read folded in
  logic signed [SumW-1:0] sum_fin;
  logic [CntW-1:0]        cnt_fin;
  assign sum_fin = rd_pend_q ? sum_q + SumW'(rv) : sum_q;
  assign cnt_fin = rd_pend_q ? cnt_q + 1'b1 : cnt_q;

  logic [SumW-1:0] mag;
  assign mag = sum_fin[SumW-1] ? SumW'(-sum_fin) : SumW'(sum_fin);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (s_axis_tvalid) state_d = StWrite;
      StWrite: state_d = StIdle;
      StScan:  if (last_cell) state_d = StLast;
      StLast:  state_d = (mode_q == nmmf_pkg::ModeMean && cnt_fin != '0) ? StDiv : StOut;
      StDiv:   if (dstep_q == 5'(SumW - 1)) state_d = StOut;
      StOut:   if (!res_vld_q || m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
    if (state_q == StWrite) state_d = StIdle;
  end

  logic in_adv_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      width_q     <= nmmf_pkg::WidthW'(1024);
      height_q    <= nmmf_pkg::HeightW'(1);
      half_q      <= nmmf_pkg::HalfW'(1);
      mode_q      <= nmmf_pkg::ModeMean;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_bank_q   <= '0;
      in_frame_q  <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_bank_q  <= '0;
      out_frame_q <= 1'b0;
      res_vld_q   <= 1'b0;
      res_last_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          nmmf_pkg::RegWidth:  width_q  <= cfg_data_i[nmmf_pkg::WidthW-1:0];
          nmmf_pkg::RegHeight: height_q <= cfg_data_i;
          nmmf_pkg::RegHalf:   half_q   <= cfg_data_i[nmmf_pkg::HalfW-1:0];
          nmmf_pkg::RegMode:   mode_q   <= cfg_data_i[nmmf_pkg::ModeW-1:0];
          default: ;
        endcase
      end
      if (state_q == StOut && (!res_vld_q || m_axis_tready)) begin
        res_vld_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        res_vld_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: ;
        StWrite: begin
          if (act_q == nmmf_pkg::ActPixel) begin
            if ((ColW+1)'(in_col_q) + 1'b1 >= wid_e) begin
              in_col_q  <= '0;
              in_bank_q <= (32'(in_bank_q) == Banks - 1) ? '0 : in_bank_q + 1'b1;
              if ((RowW+1)'(in_row_q) + 1'b1 >= hgt_e) begin
                in_row_q   <= '0;
                in_frame_q <= ~in_frame_q;
              end else begin
                in_row_q <= in_row_q + 1'b1;
              end
            end else begin
              in_col_q <= in_col_q + 1'b1;
            end
          end
        end
        StScan:  rd_pend_q <= cell_in;
        StLast:  rd_pend_q <= 1'b0;
        StDiv:   ;
        StOut: begin
          if (!res_vld_q || m_axis_tready) begin
            res_last_q <= out_wrap_col && out_wrap_row;
            if (out_wrap_col) begin
              out_col_q  <= '0;
              out_bank_q <= (32'(out_bank_q) == Banks - 1) ? '0 : out_bank_q + 1'b1;
              if (out_wrap_row) begin
                out_row_q   <= '0;
                out_frame_q <= ~out_frame_q;
              end else begin
                out_row_q <= out_row_q + 1'b1;
              end
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (state_q == StWrite && in_adv_ready) state_q <= StScan;
      else state_q <= state_d;
    end
  end

  // readiness is judged on the input position after this word is stored
  logic [ColW-1:0]  nic;
  logic [RowW-1:0]  nir;
  logic             nif;
  logic [RowW+OffW:0] rdy_lr, rdy_lc;
  always_comb begin
    nic = in_col_q;
    nir = in_row_q;
    nif = in_frame_q;
    if (act_q == nmmf_pkg::ActPixel) begin
      if ((ColW+1)'(in_col_q) + 1'b1 >= wid_e) begin
        nic = '0;
        if ((RowW+1)'(in_row_q) + 1'b1 >= hgt_e) begin
          nir = '0;
          nif = ~in_frame_q;
        end else begin
          nir = in_row_q + 1'b1;
        end
      end else begin
        nic = in_col_q + 1'b1;
      end
    end
    rdy_lr = lr;
    rdy_lc = lc;
    in_adv_ready = (nif != out_frame_q) ||
                   ((RowW+OffW+1)'(nir) > rdy_lr) ||
                   (((RowW+OffW+1)'(nir) == rdy_lr) && ((RowW+OffW+1)'(nic) > rdy_lc));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      act_q <= s_axis_tuser;
      smp_q <= s_axis_tdata;
    end
    if (state_q == StWrite) begin
      d_q   <= -$signed(k_e);
      e_q   <= -$signed(k_e);
      sum_q <= '0;
      best_q <= '0;
      cnt_q <= '0;
    end
    if (state_q == StScan) begin
      if (e_q == $signed(k_e)) begin
        e_q <= -$signed(k_e);
        d_q <= d_q + 1'b1;
      end else begin
        e_q <= e_q + 1'b1;
      end
    end
    if ((state_q == StScan || state_q == StLast) && rd_pend_q) begin
      sum_q <= sum_q + SumW'(rv);
      if (cnt_q == '0 || (mode_q == nmmf_pkg::ModeMax && rv > best_q) ||
          (mode_q == nmmf_pkg::ModeMin && rv < best_q)) begin
        best_q <= rv;
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == StLast) begin
      dstep_q <= '0;
      rem_q   <= '0;
      neg_q   <= sum_fin[SumW-1];
      quo_q   <= mag + SumW'(cnt_fin >> 1);
    end
    if (state_q == StDiv) begin
      dstep_q <= dstep_q + 1'b1;
      if (!trial[SumW]) begin
        rem_q <= trial[SumW-1:0];
        quo_q <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SumW-2:0], quo_q[SumW-1]};
        quo_q <= {quo_q[SumW-2:0], 1'b0};
      end
    end
    if (state_q == StOut && (!res_vld_q || m_axis_tready)) begin
      if (cnt_q == '0) res_q <= '0;
      else if (mode_q == nmmf_pkg::ModeMean) res_q <= neg_q ? 16'(-quo_q) : quo_q[15:0];
      else if (mode_q == nmmf_pkg::ModeMax || mode_q == nmmf_pkg::ModeMin) res_q <= best_q;
      else res_q <= '0;
    end
  end

  a_tready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (state_q == StIdle)) else $error("tready outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !m_axis_tready) |=> $stable(res_q)) else $error("result changed while held");
  a_scan_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> ready_w) else $error("window scanned before ready");

endmodule
`default_nettype wire
